/* rtl/core/dnsttl_pkg.sv */
// ----------------------------------------------------------------------------
// dnsttl_pkg
// Shared types and constants of the DNS response TTL clamper.
// ----------------------------------------------------------------------------
package dnsttl_pkg;

  localparam int unsigned MAX_MSG_BYTES_DEF = 65535;
  localparam int unsigned POS_W             = 16;
  localparam int unsigned HDR_BYTES         = 12;
  localparam int unsigned RR_FIXED_BYTES    = 10;  // type, class, ttl, rdlength
  localparam int unsigned Q_FIXED_BYTES     = 4;   // qtype, qclass
  localparam logic [7:0]  PTR_MASK          = 8'hC0;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam int unsigned CFG_IDX_W         = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TTL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TTL = 8'd1;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_NAME,
    PH_LABEL,
    PH_PTR2,
    PH_QFIXED,
    PH_RFIXED,
    PH_TTL,
    PH_RDHI,
    PH_RDLO,
    PH_RDATA,
    PH_DONE
  } phase_t;

  // One request worth of output bytes; byte i sits at bytes[8*i +: 8].
  typedef struct packed {
    logic [31:0] report;
    logic        eom;
    logic [2:0]  cnt;
    logic [31:0] bytes;
  } op_t;

  localparam int unsigned OP_W = $bits(op_t);

endpackage

/* rtl/core/dnsttl_front.sv */
// ----------------------------------------------------------------------------
// dnsttl_front
// Message parser: tracks header, names and records per byte, clamps TTLs and
// hands a packed group of output bytes to the queue.
// ----------------------------------------------------------------------------
module dnsttl_front #(
  parameter int unsigned MAX_MESSAGE_BYTES = dnsttl_pkg::MAX_MSG_BYTES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_byte,
  input  logic [15:0]             in_len,
  input  logic                    in_first,
  input  logic [31:0]             min_ttl,
  input  logic [31:0]             max_ttl,
  input  logic                    q_full,
  output logic                    q_push,
  output dnsttl_pkg::op_t         q_op
);

  localparam logic [15:0] MAX_L = MAX_MESSAGE_BYTES[15:0];

  logic [15:0]        pos_r, pos_nxt;
  dnsttl_pkg::phase_t phase_r, phase_nxt;
  logic [55:0]        hdr_r, hdr_nxt;
  logic [15:0]        qleft_r, qleft_nxt;
  logic [15:0]        rleft_r, rleft_nxt;
  logic [7:0]         lbl_r, lbl_nxt;
  logic [15:0]        fbl_r, fbl_nxt;
  logic [23:0]        hold_r, hold_nxt;
  logic [31:0]        least_r, least_nxt;
  logic               stop_r, stop_nxt;

  logic               accept;
  dnsttl_pkg::op_t    op;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept && (op.cnt != 3'd0);
  assign q_op      = op;

  always_comb begin
    logic [15:0] lenc;
    logic [16:0] p1;
    logic        last;
    logic        do_flush;
    logic [2:0]  k;
    logic [2:0]  n;
    logic [31:0] t;
    logic [63:0] full;
    logic [23:0] sh;
    lenc = (in_len > MAX_L) ? MAX_L : in_len;
    n    = 3'd0;
    op   = '0;
    t    = '0;
    full = '0;
    sh   = '0;
    k    = 3'd0;

    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    qleft_nxt = qleft_r;
    rleft_nxt = rleft_r;
    lbl_nxt   = lbl_r;
    fbl_nxt   = fbl_r;
    hold_nxt  = hold_r;
    least_nxt = least_r;
    stop_nxt  = stop_r;

    // held TTL bytes go out unchanged when the TTL gets cut off
    do_flush = !stop_r && (phase_r == dnsttl_pkg::PH_TTL) && (in_first || pos_r >= lenc);
    if (do_flush) begin
      k = 3'd4 - fbl_r[2:0];
      for (int i = 0; i < 3; i++) begin
        if (3'(i) < k) begin
          op.bytes[8*n +: 8] = hold_r[8*(k-3'd1-3'(i)) +: 8];
          n = n + 3'd1;
        end
      end
    end

    if (in_first) begin
      pos_nxt   = '0;
      phase_nxt = dnsttl_pkg::PH_HEADER;
      hdr_nxt   = '0;
      qleft_nxt = '0;
      rleft_nxt = '0;
      lbl_nxt   = '0;
      fbl_nxt   = '0;
      least_nxt = '1;
      stop_nxt  = (lenc == 16'd0);
    end else begin
      stop_nxt = stop_r || (pos_r >= lenc);
    end

    p1   = {1'b0, pos_nxt} + 17'd1;
    last = (p1 == {1'b0, lenc});

    if (!stop_nxt && phase_nxt == dnsttl_pkg::PH_TTL) begin
      hold_nxt = {hold_r[15:0], in_byte};
      if (fbl_r == 16'd1) begin
        t = {hold_r, in_byte};
        if (t < min_ttl) t = min_ttl;
        if (t > max_ttl) t = max_ttl;
        if (t < least_r) least_nxt = t;
        op.bytes = {t[7:0], t[15:8], t[23:16], t[31:24]};
        n        = 3'd4;
        op.eom   = last;
        fbl_nxt  = '0;
        phase_nxt = dnsttl_pkg::PH_RDHI;
      end else if (last) begin
        // cut-off TTL at the final byte: drops the oldest held byte, repeats the final byte
        sh = {hold_r[15:0], in_byte};
        k  = 3'd4 - fbl_r[2:0];
        for (int i = 0; i < 3; i++) begin
          if (3'(i) < k) begin
            op.bytes[8*n +: 8] = sh[8*(k-3'd1-3'(i)) +: 8];
            n = n + 3'd1;
          end
        end
        op.bytes[8*n +: 8] = in_byte;
        n        = n + 3'd1;
        op.eom   = 1'b1;
        stop_nxt = 1'b1;
      end else begin
        fbl_nxt = fbl_r - 16'd1;
      end
    end else begin
      op.bytes[8*n +: 8] = in_byte;
      n      = n + 3'd1;
      op.eom = last;
      if (!stop_nxt) begin
        case (phase_nxt)
          dnsttl_pkg::PH_HEADER: begin
            hdr_nxt = {hdr_nxt[47:0], in_byte};
            if (pos_nxt == 16'(dnsttl_pkg::HDR_BYTES - 1)) begin
              full      = {hdr_r, in_byte};
              qleft_nxt = full[63:48];
              rleft_nxt = full[47:32] + full[31:16] + full[15:0];
              phase_nxt = (qleft_nxt != '0 || rleft_nxt != '0) ?
                          dnsttl_pkg::PH_NAME : dnsttl_pkg::PH_DONE;
            end
          end
          dnsttl_pkg::PH_NAME: begin
            if (in_byte == 8'd0) begin
              if (p1 + ((qleft_nxt != '0) ? 17'(dnsttl_pkg::Q_FIXED_BYTES) :
                        17'(dnsttl_pkg::RR_FIXED_BYTES)) > {1'b0, lenc}) begin
                stop_nxt = 1'b1;
              end else begin
                phase_nxt = (qleft_nxt != '0) ? dnsttl_pkg::PH_QFIXED : dnsttl_pkg::PH_RFIXED;
                fbl_nxt   = 16'd4;
              end
            end else if ((in_byte & dnsttl_pkg::PTR_MASK) == dnsttl_pkg::PTR_MASK) begin
              if (p1 >= {1'b0, lenc}) begin
                stop_nxt = 1'b1;
              end else if (p1 + 17'd1 + ((qleft_nxt != '0) ? 17'(dnsttl_pkg::Q_FIXED_BYTES) :
                           17'(dnsttl_pkg::RR_FIXED_BYTES)) > {1'b0, lenc}) begin
                stop_nxt = 1'b1;
              end else begin
                phase_nxt = dnsttl_pkg::PH_PTR2;
              end
            end else if (p1 + 17'(in_byte) >= {1'b0, lenc}) begin
              stop_nxt = 1'b1;
            end else begin
              lbl_nxt   = in_byte;
              phase_nxt = dnsttl_pkg::PH_LABEL;
            end
          end
          dnsttl_pkg::PH_LABEL: begin
            lbl_nxt = lbl_nxt - 8'd1;
            if (lbl_nxt == 8'd0) phase_nxt = dnsttl_pkg::PH_NAME;
          end
          dnsttl_pkg::PH_PTR2: begin
            phase_nxt = (qleft_nxt != '0) ? dnsttl_pkg::PH_QFIXED : dnsttl_pkg::PH_RFIXED;
            fbl_nxt   = 16'd4;
          end
          dnsttl_pkg::PH_QFIXED: begin
            fbl_nxt = fbl_nxt - 16'd1;
            if (fbl_nxt == '0) begin
              qleft_nxt = qleft_nxt - 16'd1;
              phase_nxt = (qleft_nxt != '0 || rleft_nxt != '0) ?
                          dnsttl_pkg::PH_NAME : dnsttl_pkg::PH_DONE;
            end
          end
          dnsttl_pkg::PH_RFIXED: begin
            fbl_nxt = fbl_nxt - 16'd1;
            if (fbl_nxt == '0) begin
              phase_nxt = dnsttl_pkg::PH_TTL;
              fbl_nxt   = 16'd4;
            end
          end
          dnsttl_pkg::PH_RDHI: begin
            fbl_nxt   = {in_byte, 8'd0};
            phase_nxt = dnsttl_pkg::PH_RDLO;
          end
          dnsttl_pkg::PH_RDLO: begin
            fbl_nxt = fbl_nxt | {8'd0, in_byte};
            if (fbl_nxt == '0) begin
              rleft_nxt = rleft_nxt - 16'd1;
              phase_nxt = (rleft_nxt != '0) ? dnsttl_pkg::PH_NAME : dnsttl_pkg::PH_DONE;
            end else begin
              phase_nxt = dnsttl_pkg::PH_RDATA;
            end
          end
          dnsttl_pkg::PH_RDATA: begin
            fbl_nxt = fbl_nxt - 16'd1;
            if (fbl_nxt == '0) begin
              rleft_nxt = rleft_nxt - 16'd1;
              phase_nxt = (rleft_nxt != '0) ? dnsttl_pkg::PH_NAME : dnsttl_pkg::PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end

    if (pos_nxt < MAX_L) pos_nxt = pos_nxt + 16'd1;
    op.cnt    = n;
    op.report = (least_nxt < max_ttl) ? least_nxt : max_ttl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= dnsttl_pkg::PH_HEADER;
      hdr_r   <= '0;
      qleft_r <= '0;
      rleft_r <= '0;
      lbl_r   <= '0;
      fbl_r   <= '0;
      hold_r  <= '0;
      least_r <= '1;
      stop_r  <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      qleft_r <= qleft_nxt;
      rleft_r <= rleft_nxt;
      lbl_r   <= lbl_nxt;
      fbl_r   <= fbl_nxt;
      hold_r  <= hold_nxt;
      least_r <= least_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

/* rtl/core/dnsttl_queue.sv */
// ----------------------------------------------------------------------------
// dnsttl_queue
// Short FIFO of byte groups between parser and output sequencer.
// ----------------------------------------------------------------------------
module dnsttl_queue #(
  parameter int unsigned DEPTH = dnsttl_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dnsttl_pkg::op_t push_op,
  output logic            full,
  input  logic            pop,
  output logic            head_vld,
  output dnsttl_pkg::op_t head_op
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dnsttl_pkg::op_t     mem_r [DEPTH];
  logic [AW-1:0]       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]         cnt_r, cnt_nxt;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_op  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + (AW+1)'(1);
    if (!push && pop) cnt_nxt = cnt_r - (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_op;
  end

endmodule

/* rtl/core/dnsttl_back.sv */
// ----------------------------------------------------------------------------
// dnsttl_back
// Output sequencer: sends the bytes of each queued group one per request.
// ----------------------------------------------------------------------------
module dnsttl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_vld,
  input  dnsttl_pkg::op_t head_op,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_byte,
  output logic [31:0]     out_smallest,
  output logic            out_eom,
  output logic            out_eor
);

  logic [1:0] idx_r, idx_nxt;
  logic       item_last;

  assign item_last    = ({1'b0, idx_r} == head_op.cnt - 3'd1);
  assign out_tvalid   = head_vld;
  assign out_byte     = head_op.bytes[8*idx_r +: 8];
  assign out_eor      = item_last;
  assign out_eom      = item_last && head_op.eom;
  assign out_smallest = out_eom ? head_op.report : 32'd0;
  assign pop          = out_tvalid && out_tready && item_last;

  always_comb begin
    idx_nxt = idx_r;
    if (out_tvalid && out_tready) begin
      idx_nxt = item_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // an empty group never reaches the queue
  a_cnt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld |-> (head_op.cnt != 3'd0 && head_op.cnt <= 3'd4))
    else $error("queued group has bad byte count");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld |-> ({1'b0, idx_r} < head_op.cnt))
    else $error("byte index past group end");

  a_idx_reset_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (idx_r == 2'd0))
    else $error("index not cleared after group");

endmodule

/* rtl/core/dns_response_ttl_clamper.sv */
// ----------------------------------------------------------------------------
// dns_response_ttl_clamper
// Streams DNS messages through and clamps every resource record TTL.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle while the queue has room (in_tready high) and sends
// it out again, except that each answer, authority and additional record TTL is
// clamped to [min_ttl, max_ttl] (max_ttl wins if they cross). TTL bytes are held until
// the fourth arrives and then come out as four back-to-back output requests, so one
// input byte gives zero to four outputs; the output side sustains one byte per cycle
// while out_tready is high, and a four-entry queue between parser and output sequencer
// absorbs the bursts. With tlast (the final byte) the smallest clamped TTL appears in
// tdata, or max_ttl if none. Malformed or short messages pass unchanged from the point
// of trouble on, except that a TTL cut off by the final byte may be altered.
module dns_response_ttl_clamper #(
  parameter int unsigned MAX_MESSAGE_BYTES = dnsttl_pkg::MAX_MSG_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,  // in_byte[7:0], msg_length[23:8]
  input  logic                             in_tuser,  // first_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [39:0]                      out_tdata, // out_byte[7:0], smallest_ttl[39:8]
  output logic                             out_tlast, // end_of_message
  output logic                             out_tuser, // end_of_run
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dnsttl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  logic [31:0]     min_ttl_r, min_ttl_nxt;
  logic [31:0]     max_ttl_r, max_ttl_nxt;
  logic            q_full, q_push, q_pop, head_vld;
  dnsttl_pkg::op_t push_op, head_op;
  logic [7:0]      out_byte;
  logic [31:0]     out_smallest;

  assign cfg_ready = 1'b1;
  assign out_tdata = {out_smallest, out_byte};

  always_comb begin
    min_ttl_nxt = min_ttl_r;
    max_ttl_nxt = max_ttl_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dnsttl_pkg::CFG_MIN_TTL: min_ttl_nxt = cfg_data;
        dnsttl_pkg::CFG_MAX_TTL: max_ttl_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ttl_r <= '0;
      max_ttl_r <= '1;
    end else begin
      min_ttl_r <= min_ttl_nxt;
      max_ttl_r <= max_ttl_nxt;
    end
  end

  dnsttl_front #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_byte  (in_tdata[7:0]),
    .in_len   (in_tdata[23:8]),
    .in_first (in_tuser),
    .min_ttl  (min_ttl_r),
    .max_ttl  (max_ttl_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_op     (push_op)
  );

  dnsttl_queue #(
    .DEPTH(dnsttl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .head_vld(head_vld),
    .head_op (head_op)
  );

  dnsttl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_vld    (head_vld),
    .head_op     (head_op),
    .pop         (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_byte    (out_byte),
    .out_smallest(out_smallest),
    .out_eom     (out_tlast),
    .out_eor     (out_tuser)
  );

  a_eom_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser)
    else $error("end of message not on last byte of its group");

  a_report_only_at_eom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[39:8] == 32'd0))
    else $error("smallest ttl reported off end of message");

  a_report_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast && $stable(max_ttl_r)) |-> (out_tdata[39:8] <= max_ttl_r))
    else $error("reported ttl above max");

endmodule
